// ----- rtl/smm_pkg.sv -----
// ----------------------------------------------------------------------------
// smm_pkg
// Shared types and constants for the square matrix multiplier.
// ----------------------------------------------------------------------------
package smm_pkg;

    // Default largest matrix dimension
    localparam int DEFAULT_MAX_DIM = 8;

    // Field widths
    localparam int DIM_CFG_W  = 4;
    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = 35;
    localparam int IN_TDATA_W = 2 * ELEM_W;
    localparam int OUT_TDATA_W = ((ACC_W + 7) / 8) * 8;

    // Dimension register after reset
    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 4'd8;

    // Sequencer states
    typedef enum logic
    {
        ST_LOAD,
        ST_COMPUTE
    } smm_state_t;

    // Tag that travels with each memory read down the MAC pipeline
    typedef struct packed
    {
        logic valid;
        logic first_k;
        logic last_k;
        logic last_elem;
    } smm_tag_t;

endpackage

// ----- rtl/smm_ram.sv -----
// ----------------------------------------------------------------------------
// smm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module smm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/smm_seq.sv -----
// ----------------------------------------------------------------------------
// smm_seq
// Load counter and i/j/k read sequencer; drives both element memories.
// ----------------------------------------------------------------------------
module smm_seq #(
    parameter int MAX_DIM = smm_pkg::DEFAULT_MAX_DIM
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wr_en,
    input  logic [smm_pkg::DIM_CFG_W-1:0]             cfg_wr_data,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic                                      adv,
    output logic                                      wr_en,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        wr_addr,
    output logic                                      rd_en,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        a_rd_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]        b_rd_addr,
    output smm_pkg::smm_tag_t                         tag
);

    import smm_pkg::*;

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int CNT_W  = $clog2(CELLS + 1);

    smm_state_t             state_reg, state_next;
    logic [DIM_CFG_W-1:0]   dim_reg;
    logic [CNT_W-1:0]       load_count_reg, load_count_next;
    logic [IDX_W-1:0]       i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [ADDR_W-1:0]      a_base_reg, a_base_next, b_base_reg, b_base_next;
    logic [DIM_W-1:0]       n;
    logic [IDX_W-1:0]       n_m1;
    logic [CNT_W-1:0]       total;
    logic [CNT_W-1:0]       count_inc;
    logic                   accept;
    logic                   issue;

    // Effective dimension: zero acts as one, oversize clamps to MAX_DIM
    always_comb
    begin
        priority if (dim_reg == '0)
        begin
            n = DIM_W'(1);
        end
        else if (32'(dim_reg) > MAX_DIM)
        begin
            n = DIM_W'(MAX_DIM);
        end
        else
        begin
            n = DIM_W'(dim_reg);
        end
    end

    assign n_m1      = IDX_W'(n - DIM_W'(1));
    assign total     = CNT_W'(CNT_W'(n) * CNT_W'(n));
    assign count_inc = load_count_reg + CNT_W'(1);

    // Handshake and memory controls
    assign in_ready  = (state_reg == ST_LOAD);
    assign accept    = in_valid && in_ready;
    assign wr_en     = accept && (32'(load_count_reg) < CELLS);
    assign wr_addr   = load_count_reg[ADDR_W-1:0];
    assign issue     = (state_reg == ST_COMPUTE) && adv;
    assign rd_en     = issue;
    assign a_rd_addr = a_base_reg + ADDR_W'(k_reg);
    assign b_rd_addr = b_base_reg + ADDR_W'(j_reg);

    assign tag.valid     = issue;
    assign tag.first_k   = (k_reg == '0);
    assign tag.last_k    = (k_reg == n_m1);
    assign tag.last_elem = (i_reg == n_m1) && (j_reg == n_m1);

    // Dimension register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= DIM_RESET;
        end
        else if (cfg_wr_en)
        begin
            dim_reg <= cfg_wr_data;
        end
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            load_count_reg <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            a_base_reg     <= '0;
            b_base_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            load_count_reg <= load_count_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            k_reg          <= k_next;
            a_base_reg     <= a_base_next;
            b_base_reg     <= b_base_next;
        end
    end

    // Next state: load items, then walk i, j, k issuing one read pair a cycle while adv is high
    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        a_base_next     = a_base_reg;
        b_base_next     = b_base_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_inc >= total)
                    begin
                        load_count_next = '0;
                        state_next      = ST_COMPUTE;
                    end
                    else
                    begin
                        load_count_next = count_inc;
                    end
                end
            end
            ST_COMPUTE:
            begin
                if (issue)
                begin
                    if (!tag.last_k)
                    begin
                        k_next      = k_reg + IDX_W'(1);
                        b_base_next = b_base_reg + ADDR_W'(n);
                    end
                    else
                    begin
                        k_next      = '0;
                        b_base_next = '0;
                        if (j_reg != n_m1)
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = '0;
                            if (tag.last_elem)
                            begin
                                i_next      = '0;
                                a_base_next = '0;
                                state_next  = ST_LOAD;
                            end
                            else
                            begin
                                i_next      = i_reg + IDX_W'(1);
                                a_base_next = a_base_reg + ADDR_W'(n);
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // Load count stays inside the memory
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(load_count_reg) < CELLS)
        else $error("load count beyond memory depth");

    // Every read falls inside the loaded matrix
    assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (CNT_W'(a_rd_addr) < total) && (CNT_W'(b_rd_addr) < total))
        else $error("read address outside matrix");

    // Final read of the matrix hands back to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (issue && tag.last_k && tag.last_elem) |=> (state_reg == ST_LOAD))
        else $error("sequencer did not return to load");
`endif

endmodule

// ----- rtl/smm_mac.sv -----
// ----------------------------------------------------------------------------
// smm_mac
// Multiply-accumulate pipeline behind the memories, with the output register.
// ----------------------------------------------------------------------------
module smm_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  smm_pkg::smm_tag_t            tag,
    input  logic [smm_pkg::ELEM_W-1:0]   a_rd,
    input  logic [smm_pkg::ELEM_W-1:0]   b_rd,
    output logic                         adv,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [smm_pkg::ACC_W-1:0]    out_data,
    output logic                         out_last
);

    import smm_pkg::*;

    smm_tag_t                s1_tag_reg;
    smm_tag_t                s2_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W-1:0]  sum;
    logic                     out_valid_reg;
    logic [ACC_W-1:0]         out_data_reg;
    logic                     out_last_reg;
    logic                     done;

    // Element finishes in the accumulate stage
    assign done = s2_tag_reg.valid && s2_tag_reg.last_k;
    assign adv  = !(done && out_valid_reg && !out_ready);

    assign acc_base = s2_tag_reg.first_k ? '0 : acc_reg;
    assign sum      = acc_base + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Tag pipeline and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg    <= '0;
            s2_tag_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_tag_reg <= tag;
                s2_tag_reg <= s1_tag_reg;
            end
            if (adv && done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath: multiply, accumulate, capture result
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= $signed(a_rd) * $signed(b_rd);
            if (s2_tag_reg.valid)
            begin
                acc_reg <= sum;
            end
            if (done)
            begin
                out_data_reg <= sum;
                out_last_reg <= s2_tag_reg.last_elem;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

`ifndef NO_ASSERTIONS
    // A stall only happens with a result waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |-> (out_valid_reg && done))
        else $error("pipeline stalled without a pending result");

    // A new result appears only after a finished element
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done && adv))
        else $error("result appeared without a finished element");

    // Accumulation of a fresh element starts with its first term
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_tag_reg.valid && s2_tag_reg.last_k && s2_tag_reg.first_k)
            |=> (out_data_reg == $past(32'(0) + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}},
                prod_reg})))
        else $error("single-term element mismatch");
`endif

endmodule

// ----- rtl/square_matrix_multiply.sv -----
// ----------------------------------------------------------------------------
// square_matrix_multiply
// Loads two n x n signed 16-bit matrices one element pair per item, then
// streams out their 35-bit product row-major with tlast on the final element.
// ----------------------------------------------------------------------------
// During loading the input is always ready. After the n*n-th item the input
// stalls while the sequencer, whenever the pipeline is not held, reads one A
// element and one B element per cycle from the two element memories (a single
// read port each) into one multiply-accumulate unit. Each pair passes the
// memory read registers, the product register and the accumulator, and an
// element's final sum goes into the output register. A full output register
// with tready low holds the pipeline once another result is ready for it. The
// next load may begin while the last results still drain.
module square_matrix_multiply #(
    parameter int MAX_DIM = smm_pkg::DEFAULT_MAX_DIM
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [smm_pkg::DIM_CFG_W-1:0]        cfg_wr_data,   // dim
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [smm_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // a_element, b_element
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [smm_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // product_element, zero pad
    output logic                                 m_axis_tlast   // last
);

    import smm_pkg::*;

    localparam int CELLS  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(CELLS);

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   a_rd_addr;
    logic [ADDR_W-1:0]   b_rd_addr;
    logic [ELEM_W-1:0]   a_rd;
    logic [ELEM_W-1:0]   b_rd;
    logic                adv;
    smm_tag_t            tag;
    logic [ACC_W-1:0]    product;

    // Sequencer
    smm_seq #(
        .MAX_DIM (MAX_DIM)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .adv         (adv),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .rd_en       (rd_en),
        .a_rd_addr   (a_rd_addr),
        .b_rd_addr   (b_rd_addr),
        .tag         (tag)
    );

    // Matrix A store
    smm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CELLS)
    ) u_store_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_axis_tdata[ELEM_W-1:0]),
        .re    (rd_en),
        .raddr (a_rd_addr),
        .rdata (a_rd)
    );

    // Matrix B store
    smm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (CELLS)
    ) u_store_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (s_axis_tdata[2*ELEM_W-1:ELEM_W]),
        .re    (rd_en),
        .raddr (b_rd_addr),
        .rdata (b_rd)
    );

    // Multiply-accumulate and output register
    smm_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .tag       (tag),
        .a_rd      (a_rd),
        .b_rd      (b_rd),
        .adv       (adv),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (product),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-ACC_W){1'b0}}, product};

endmodule
